[hw/rtl/segment_plane_intersect_core_defines.svh]
// Assertion macros shared by the segment/plane intersection RTL.
// Depends on a clk and an arst_n signal in the module that uses them.
`ifndef SEGMENT_PLANE_INTERSECT_CORE_DEFINES_SVH
`define SEGMENT_PLANE_INTERSECT_CORE_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define SPI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while in reset.
`define SPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/spi_pkg.sv]
// Shared types and operation codes for the segment/plane intersection core.
// No dependencies.
package spi_pkg;

	localparam logic [2:0] OP_HOLD = 3'd0;
	localparam logic [2:0] OP_LOAD = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_CHK  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic       load_acc;
		logic       neg;
		logic       sign_step;
	} spi_ctl_t;

endpackage

[hw/rtl/spi_in_if.sv]
// Input channel: one item with a kind bit and three points.
// Depends on nothing.
interface spi_in_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] first_z;
	logic signed [COORD_BITS-1:0] second_x;
	logic signed [COORD_BITS-1:0] second_y;
	logic signed [COORD_BITS-1:0] second_z;
	logic signed [COORD_BITS-1:0] third_x;
	logic signed [COORD_BITS-1:0] third_y;
	logic signed [COORD_BITS-1:0] third_z;

	modport source (output valid, kind, first_x, first_y, first_z, second_x, second_y,
		second_z, third_x, third_y, third_z, input ready);
	modport sink (input valid, kind, first_x, first_y, first_z, second_x, second_y,
		second_z, third_x, third_y, third_z, output ready);
endinterface

[hw/rtl/spi_out_if.sv]
// Result channel: intersection point and status flags.
// Depends on nothing.
interface spi_out_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] hit_x;
	logic signed [COORD_BITS-1:0] hit_y;
	logic signed [COORD_BITS-1:0] hit_z;
	logic                         is_parallel;
	logic                         start_on_plane;
	logic                         clipped;

	modport source (output valid, hit_x, hit_y, hit_z, is_parallel, start_on_plane,
		clipped, input ready);
	modport sink (input valid, hit_x, hit_y, hit_z, is_parallel, start_on_plane,
		clipped, output ready);
endinterface

[hw/rtl/segment_plane_intersect_core.sv]
// Top level of the segment/plane intersection core: sequencer, plane store.
// Depends on spi_pkg, spi_in_if, spi_out_if, spi_shared_unit and the defines header.
`include "segment_plane_intersect_core_defines.svh"

// One item at a time; item.ready is high only while the core is idle. Every
// product goes through one bit-serial add/subtract unit, one multiplier bit per
// cycle, and nine products are needed per item. A kind-0 item (plane load)
// gives no result. A kind-1 item adds a restoring divide for t (skipped when
// numerator or denominator is zero) before the result is offered. The result
// waits in its own output register, so the next item is taken at once; a line
// only stalls at its last step while the previous result is still not taken.
module segment_plane_intersect_core #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 24
) (
	input logic clk,
	input logic arst_n,
	spi_in_if.sink    item,
	spi_out_if.source result
);

	localparam int C    = COORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int DW   = C + 1;
	localparam int NW   = 2 * C + 4;
	localparam int OW   = 3 * C + 7;
	localparam int NUMW = OW + 2;
	localparam int QB   = C + F + 2;
	localparam int TW   = QB + 1;
	localparam int AW1  = OW + C + 4;
	localparam int AW2  = TW + DW + 2;
	localparam int AW   = (AW1 > AW2) ? AW1 : AW2;
	localparam int VW   = AW - F;
	localparam int BCW  = $clog2(DW);
	localparam int QCW  = $clog2(QB);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOAD   = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_POST   = 3'd3;
	localparam logic [2:0] S_DIVSET = 3'd4;
	localparam logic [2:0] S_CHK    = 3'd5;
	localparam logic [2:0] S_DIV    = 3'd6;
	localparam logic [2:0] S_ROUND  = 3'd7;

	localparam logic [3:0] IDX_LAST = 4'd8;

	localparam logic signed [VW-1:0] VHI = {{(VW-C+1){1'b0}}, {(C-1){1'b1}}};
	localparam logic signed [VW-1:0] VLO = ~VHI;
	localparam logic [QB-1:0] CAP = {1'b1, {(QB-1){1'b0}}};

	logic [2:0]     state_q;
	logic [3:0]     idx_q;
	logic [BCW-1:0] bit_cnt_q;
	logic [QCW-1:0] div_cnt_q;
	logic           out_valid_q;

	logic                  kind_q;
	logic signed [C-1:0]   p1x_q, p1y_q, p1z_q, p2x_q, p2y_q, p2z_q, p3x_q, p3y_q, p3z_q;
	logic signed [NW-1:0]  na_q, nb_q, nc_q;
	logic signed [OW-1:0]  d_q;
	logic signed [NUMW-1:0] num_q, den_q;
	logic [QB-1:0]         q_q;
	logic                  ovf_q;
	logic signed [TW-1:0]  tq_q;
	logic signed [C-1:0]   hx_q, hy_q;
	logic                  par_q, onp_q, clip_q;
	logic signed [C-1:0]   res_x_q, res_y_q, res_z_q;
	logic                  res_par_q, res_onp_q, res_clip_q;

	logic signed [DW-1:0] a1, b1, c1, a2, b2, c2;
	logic signed [DW-1:0] x1e, y1e, z1e;

	spi_pkg::spi_ctl_t ctl;
	logic [AW-1:0]     acc_init_c, mcand_c, acc;
	logic [DW-1:0]     mpl_c;
	logic              load_acc_c, neg_c, ge;

	logic                  num_zero, den_zero;
	logic [NUMW-1:0]       num_abs, den_abs;
	logic [QB-1:0]         mag;
	logic [QB:0]           q_inc;
	logic signed [VW-1:0]  v;
	logic signed [C-1:0]   v_sat;
	logic                  v_clip;
	logic                  item_acc;
	logic                  res_free;
	logic                  res_load;

	assign item_acc = item.valid && item.ready;
	assign res_free = !out_valid_q || result.ready;
	assign res_load = (state_q == S_POST) && kind_q && (idx_q == IDX_LAST) && res_free;

	assign a1  = {p2x_q[C-1], p2x_q} - {p1x_q[C-1], p1x_q};
	assign b1  = {p2y_q[C-1], p2y_q} - {p1y_q[C-1], p1y_q};
	assign c1  = {p2z_q[C-1], p2z_q} - {p1z_q[C-1], p1z_q};
	assign a2  = {p3x_q[C-1], p3x_q} - {p1x_q[C-1], p1x_q};
	assign b2  = {p3y_q[C-1], p3y_q} - {p1y_q[C-1], p1y_q};
	assign c2  = {p3z_q[C-1], p3z_q} - {p1z_q[C-1], p1z_q};
	assign x1e = {p1x_q[C-1], p1x_q};
	assign y1e = {p1y_q[C-1], p1y_q};
	assign z1e = {p1z_q[C-1], p1z_q};

	assign num_zero = (num_q == '0);
	assign den_zero = (den_q == '0);
	assign num_abs  = num_q[NUMW-1] ? -num_q : num_q;
	assign den_abs  = den_q[NUMW-1] ? -den_q : den_q;

	// Operand selection for each product term
	always_comb begin
		mcand_c    = '0;
		mpl_c      = '0;
		acc_init_c = '0;
		load_acc_c = 1'b0;
		neg_c      = 1'b0;
		if (!kind_q) begin
			case (idx_q)
				4'd0: begin mcand_c = AW'(b1); mpl_c = c2; load_acc_c = 1'b1; end
				4'd1: begin mcand_c = AW'(b2); mpl_c = c1; neg_c = 1'b1; end
				4'd2: begin mcand_c = AW'(a2); mpl_c = c1; load_acc_c = 1'b1; end
				4'd3: begin mcand_c = AW'(a1); mpl_c = c2; neg_c = 1'b1; end
				4'd4: begin mcand_c = AW'(a1); mpl_c = b2; load_acc_c = 1'b1; end
				4'd5: begin mcand_c = AW'(b1); mpl_c = a2; neg_c = 1'b1; end
				4'd6: begin
					mcand_c = AW'(na_q); mpl_c = x1e; load_acc_c = 1'b1; neg_c = 1'b1;
				end
				4'd7: begin mcand_c = AW'(nb_q); mpl_c = y1e; neg_c = 1'b1; end
				4'd8: begin mcand_c = AW'(nc_q); mpl_c = z1e; neg_c = 1'b1; end
				default: begin mcand_c = '0; mpl_c = '0; end
			endcase
		end else begin
			case (idx_q)
				4'd0: begin
					mcand_c = AW'(na_q); mpl_c = x1e; load_acc_c = 1'b1;
					acc_init_c = AW'(d_q);
				end
				4'd1: begin mcand_c = AW'(nb_q); mpl_c = y1e; end
				4'd2: begin mcand_c = AW'(nc_q); mpl_c = z1e; end
				4'd3: begin mcand_c = AW'(na_q); mpl_c = a1; load_acc_c = 1'b1; end
				4'd4: begin mcand_c = AW'(nb_q); mpl_c = b1; end
				4'd5: begin mcand_c = AW'(nc_q); mpl_c = c1; end
				4'd6: begin
					mcand_c = AW'(tq_q); mpl_c = a1; load_acc_c = 1'b1;
					acc_init_c = (AW'(p1x_q) << F) | (AW'(1) << (F - 1));
				end
				4'd7: begin
					mcand_c = AW'(tq_q); mpl_c = b1; load_acc_c = 1'b1;
					acc_init_c = (AW'(p1y_q) << F) | (AW'(1) << (F - 1));
				end
				4'd8: begin
					mcand_c = AW'(tq_q); mpl_c = c1; load_acc_c = 1'b1;
					acc_init_c = (AW'(p1z_q) << F) | (AW'(1) << (F - 1));
				end
				default: begin mcand_c = '0; mpl_c = '0; end
			endcase
		end
		if (state_q == S_DIVSET) begin
			acc_init_c = AW'(num_abs);
			mcand_c    = AW'(den_abs) << C;
			load_acc_c = 1'b1;
		end
	end

	always_comb begin
		ctl.op        = spi_pkg::OP_HOLD;
		ctl.load_acc  = load_acc_c;
		ctl.neg       = neg_c;
		ctl.sign_step = (bit_cnt_q == BCW'(DW - 1));
		case (state_q)
			S_LOAD:   ctl.op = spi_pkg::OP_LOAD;
			S_MUL:    ctl.op = spi_pkg::OP_MUL;
			S_DIVSET: ctl.op = (num_zero || den_zero) ? spi_pkg::OP_HOLD : spi_pkg::OP_LOAD;
			S_CHK:    ctl.op = spi_pkg::OP_CHK;
			S_DIV:    ctl.op = spi_pkg::OP_DIV;
			default:  ctl.op = spi_pkg::OP_HOLD;
		endcase
	end

	spi_shared_unit #(.AW(AW), .MW(DW)) u_unit (
		.clk        (clk),
		.ctl        (ctl),
		.acc_init   (acc_init_c),
		.mcand_init (mcand_c),
		.mpl_init   (mpl_c),
		.acc        (acc),
		.ge         (ge)
	);

	// Round t magnitude to nearest, ties away from zero
	assign q_inc = {1'b0, q_q} + (QB+1)'(1);
	assign mag   = ovf_q ? CAP : q_inc[QB:1];

	// Coordinate result: floor of the accumulator by 2^F, then saturate
	assign v = acc[AW-1:F];
	always_comb begin
		v_clip = 1'b0;
		v_sat  = v[C-1:0];
		if (v > VHI) begin
			v_sat  = {1'b0, {(C-1){1'b1}}};
			v_clip = 1'b1;
		end else if (v < VLO) begin
			v_sat  = {1'b1, {(C-1){1'b0}}};
			v_clip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			bit_cnt_q   <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			na_q        <= '0;
			nb_q        <= '0;
			nc_q        <= '0;
			d_q         <= '0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						idx_q   <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					bit_cnt_q <= '0;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					bit_cnt_q <= bit_cnt_q + BCW'(1);
					if (bit_cnt_q == BCW'(DW - 1)) state_q <= S_POST;
				end
				S_POST: begin
					if (!kind_q) begin
						idx_q   <= idx_q + 4'd1;
						state_q <= (idx_q == IDX_LAST) ? S_IDLE : S_LOAD;
						case (idx_q)
							4'd1: na_q <= acc[NW-1:0];
							4'd3: nb_q <= acc[NW-1:0];
							4'd5: nc_q <= acc[NW-1:0];
							4'd8: d_q  <= acc[OW-1:0];
							default: ;
						endcase
					end else begin
						case (idx_q)
							4'd5: begin
								idx_q   <= idx_q + 4'd1;
								state_q <= S_DIVSET;
							end
							IDX_LAST: begin
								// hold until the previous result transaction has left
								if (res_free) state_q <= S_IDLE;
							end
							default: begin
								idx_q   <= idx_q + 4'd1;
								state_q <= S_LOAD;
							end
						endcase
					end
				end
				S_DIVSET: begin
					// zero numerator or denominator: t stays zero, skip the divide
					state_q <= (num_zero || den_zero) ? S_LOAD : S_CHK;
				end
				S_CHK: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + QCW'(1);
					if (div_cnt_q == QCW'(QB - 1)) state_q <= S_ROUND;
				end
				S_ROUND: begin
					state_q <= S_LOAD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload and datapath registers
	always_ff @(posedge clk) begin
		if (item_acc) begin
			kind_q <= item.kind;
			p1x_q  <= item.first_x;
			p1y_q  <= item.first_y;
			p1z_q  <= item.first_z;
			p2x_q  <= item.second_x;
			p2y_q  <= item.second_y;
			p2z_q  <= item.second_z;
			p3x_q  <= item.third_x;
			p3y_q  <= item.third_y;
			p3z_q  <= item.third_z;
		end
		if (state_q == S_POST && kind_q) begin
			case (idx_q)
				4'd2: num_q <= acc[NUMW-1:0];
				4'd5: den_q <= acc[NUMW-1:0];
				4'd6: begin hx_q <= v_sat; clip_q <= clip_q | v_clip; end
				4'd7: begin hy_q <= v_sat; clip_q <= clip_q | v_clip; end
				default: clip_q <= clip_q;
			endcase
		end
		if (state_q == S_DIVSET) begin
			par_q  <= den_zero;
			onp_q  <= num_zero;
			clip_q <= 1'b0;
			tq_q   <= '0;
		end
		if (state_q == S_CHK) ovf_q <= ge;
		if (state_q == S_DIV) q_q <= {q_q[QB-2:0], ge};
		if (state_q == S_ROUND) begin
			// t is negative when numerator and denominator share a sign
			tq_q <= (num_q[NUMW-1] == den_q[NUMW-1]) ? -$signed({1'b0, mag})
				: $signed({1'b0, mag});
		end
		if (res_load) begin
			res_x_q    <= hx_q;
			res_y_q    <= hy_q;
			res_z_q    <= v_sat;
			res_par_q  <= par_q;
			res_onp_q  <= onp_q;
			res_clip_q <= clip_q | v_clip;
		end
	end

	assign item.ready            = (state_q == S_IDLE);
	assign result.valid          = out_valid_q;
	assign result.hit_x          = res_x_q;
	assign result.hit_y          = res_y_q;
	assign result.hit_z          = res_z_q;
	assign result.is_parallel    = res_par_q;
	assign result.start_on_plane = res_onp_q;
	assign result.clipped        = res_clip_q;

	`SPI_ASSERT_NOW(a_ready_excl, item.ready, state_q == S_IDLE, "ready while busy")
	`SPI_ASSERT_NOW(a_flag_noclip, result.valid && (result.is_parallel || result.start_on_plane), !result.clipped, "clipped with t forced to zero")
	`SPI_ASSERT_NEXT(a_load_silent, item_acc && !item.kind && !result.valid, !result.valid, "plane load produced a result")
	`SPI_ASSERT_NEXT(a_res_hold, result.valid && !result.ready, result.valid && $stable(result.hit_x), "result dropped while stalled")
	`SPI_ASSERT_NOW(a_div_bound, state_q == S_DIV, div_cnt_q <= QCW'(QB - 1), "divide counter overran")

endmodule

[hw/rtl/spi_shared_unit.sv]
// Shared add/subtract unit: bit-serial signed multiply-accumulate and
// restoring divide steps. Depends on spi_pkg.
module spi_shared_unit #(
	parameter int AW = 75,
	parameter int MW = 17
) (
	input  logic              clk,
	input  spi_pkg::spi_ctl_t ctl,
	input  logic [AW-1:0]     acc_init,
	input  logic [AW-1:0]     mcand_init,
	input  logic [MW-1:0]     mpl_init,
	output logic [AW-1:0]     acc,
	output logic              ge
);

	logic [AW-1:0] acc_q;
	logic [AW-1:0] mcand_q;
	logic [MW-1:0] mpl_q;
	logic [AW-1:0] opd;
	logic          sub;
	logic [AW-1:0] sum;

	always_comb begin
		opd = '0;
		sub = 1'b0;
		case (ctl.op)
			spi_pkg::OP_MUL: begin
				opd = mpl_q[0] ? mcand_q : '0;
				// the top multiplier bit weighs negative
				sub = ctl.neg ^ ctl.sign_step;
			end
			spi_pkg::OP_CHK: begin
				opd = mcand_q << 1;
				sub = 1'b1;
			end
			spi_pkg::OP_DIV: begin
				opd = mcand_q;
				sub = 1'b1;
			end
			default: begin
				opd = '0;
				sub = 1'b0;
			end
		endcase
	end

	assign sum = acc_q + (sub ? ~opd : opd) + AW'(sub);
	assign ge  = ~sum[AW-1];
	assign acc = acc_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			spi_pkg::OP_LOAD: begin
				if (ctl.load_acc) acc_q <= acc_init;
				mcand_q <= mcand_init;
				mpl_q   <= mpl_init;
			end
			spi_pkg::OP_MUL: begin
				acc_q   <= sum;
				mcand_q <= mcand_q << 1;
				mpl_q   <= mpl_q >> 1;
			end
			spi_pkg::OP_DIV: begin
				acc_q <= ge ? (sum << 1) : (acc_q << 1);
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

[tb/segment_plane_intersect_core_tb.sv]
// Self-checking testbench for segment_plane_intersect_core: plane loads and line hits.
// Depends on the RTL interfaces spi_in_if and spi_out_if and on the core itself.
module segment_plane_intersect_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 16;
	localparam int FB = 24;
	localparam int N_RANDOM = 1930;
	localparam int DRAIN_CYCLES = 250;
	localparam int PRESSURE_AT = 300;
	localparam int PRESSURE_LEN = 2000;
	localparam int QUIET_LO = 900;
	localparam int QUIET_HI = 1200;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_LINE = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [8:0][CB-1:0]  c;
	} seg_item_t;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] z;
		logic          par;
		logic          onp;
		logic          clip;
	} hit_t;

	typedef struct packed {
		seg_item_t item;
		logic      typed;
		hit_t      hit;
	} stim_row_t;

	logic clk;
	logic arst_n;

	spi_in_if  #(.COORD_BITS(CB)) item_if();
	spi_out_if #(.COORD_BITS(CB)) result_if();

	segment_plane_intersect_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if.sink),
		.result(result_if.source)
	);

	longint    nrm_a, nrm_b, nrm_c, offset_d;
	hit_t      pending_hits[$];
	stim_row_t dir_rows[$];
	int        n_fail;
	int        n_accepted;
	logic      [2:0][CB-1:0] last_plane_pt;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#60ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic longint wrap_bits(longint v, int w);
		longint s;
		s = v <<< (64 - w);
		return s >>> (64 - w);
	endfunction

	function automatic longint t_mag(longint unsigned n, longint unsigned d);
		longint unsigned cap, qi, r, q;
		cap = 64'd1 << (CB + 1 + FB);
		qi = n / d;
		r = n % d;
		if (qi >= (64'd1 << (CB + 1)))
			return longint'(cap);
		q = qi;
		for (int i = 0; i < FB + 1; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		q = (q + 64'd1) >> 1;
		if (q > cap)
			q = cap;
		return longint'(q);
	endfunction

	// Advance the plane store for a load, or work out the hit for a line.
	function automatic hit_t predict_hit(seg_item_t it);
		longint p[9];
		longint stp[3];
		longint num, den, tq, t_int, t_frac, v;
		longint lo, hi;
		hit_t h;
		logic [2:0][CB-1:0] outc;
		for (int i = 0; i < 9; i++)
			p[i] = longint'($signed(it.c[i]));
		h = '0;
		if (it.kind == KIND_LOAD) begin
			longint a1, b1, c1, a2, b2, c2;
			a1 = p[3] - p[0]; b1 = p[4] - p[1]; c1 = p[5] - p[2];
			a2 = p[6] - p[0]; b2 = p[7] - p[1]; c2 = p[8] - p[2];
			nrm_a = wrap_bits(b1 * c2 - b2 * c1, 36);
			nrm_b = wrap_bits(a2 * c1 - a1 * c2, 36);
			nrm_c = wrap_bits(a1 * b2 - b1 * a2, 36);
			offset_d = wrap_bits(-(nrm_a * p[0] + nrm_b * p[1] + nrm_c * p[2]), 55);
			return h;
		end
		for (int i = 0; i < 3; i++)
			stp[i] = p[i + 3] - p[i];
		num = offset_d + nrm_a * p[0] + nrm_b * p[1] + nrm_c * p[2];
		den = nrm_a * stp[0] + nrm_b * stp[1] + nrm_c * stp[2];
		tq = 0;
		if (num != 0 && den != 0) begin
			longint mag;
			mag = t_mag(longint'(num < 0 ? -num : num), longint'(den < 0 ? -den : den));
			tq = ((num < 0) == (den < 0)) ? -mag : mag;
		end
		t_int = tq >>> FB;
		t_frac = tq - (t_int <<< FB);
		hi = (64'sd1 <<< (CB - 1)) - 1;
		lo = -(64'sd1 <<< (CB - 1));
		for (int i = 0; i < 3; i++) begin
			v = p[i] + stp[i] * t_int + ((stp[i] * t_frac + (64'sd1 <<< (FB - 1))) >>> FB);
			if (v > hi) begin
				v = hi;
				h.clip = 1'b1;
			end
			if (v < lo) begin
				v = lo;
				h.clip = 1'b1;
			end
			outc[i] = v[CB-1:0];
		end
		h.x = outc[0];
		h.y = outc[1];
		h.z = outc[2];
		h.par = (den == 0);
		h.onp = (num == 0);
		return h;
	endfunction

	function automatic void add_row(logic kind, int c0, int c1, int c2, int c3, int c4,
		int c5, int c6, int c7, int c8, logic typed, int hx, int hy, int hz,
		logic par, logic onp, logic clip);
		stim_row_t r;
		int cs[9];
		cs = '{c0, c1, c2, c3, c4, c5, c6, c7, c8};
		r.item.kind = kind;
		for (int i = 0; i < 9; i++)
			r.item.c[i] = cs[i][CB-1:0];
		r.typed = typed;
		r.hit.x = hx[CB-1:0];
		r.hit.y = hy[CB-1:0];
		r.hit.z = hz[CB-1:0];
		r.hit.par = par;
		r.hit.onp = onp;
		r.hit.clip = clip;
		dir_rows.push_back(r);
	endfunction

	function automatic logic [CB-1:0] rand_coord(bit full);
		int s;
		if (full)
			return CB'($urandom_range(0, 65535));
		s = $urandom_range(0, 400);
		s = s - 200;
		return s[CB-1:0];
	endfunction

	function automatic seg_item_t rand_item();
		seg_item_t it;
		int sel;
		bit full;
		sel = $urandom_range(0, 99);
		full = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < 9; i++)
			it.c[i] = rand_coord(full);
		it.kind = KIND_LINE;
		if (sel < 15) begin
			it.kind = KIND_LOAD;
		end else if (sel < 22) begin
			for (int i = 0; i < 9; i++)
				it.c[i] = rand_coord(1);
		end else if (sel < 30) begin
			for (int i = 0; i < 3; i++)
				it.c[i + 3] = it.c[i];
		end else if (sel < 38) begin
			for (int i = 0; i < 3; i++)
				it.c[i] = last_plane_pt[i];
		end
		return it;
	endfunction

	task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
		n_fail++;
	endtask

	// Drive one transaction; gaps are inserted ahead of it at random, except in the quiet window.
	task automatic send_item(seg_item_t it, logic typed, hit_t typed_hit);
		hit_t h;
		bit quiet;
		quiet = (n_accepted >= QUIET_LO && n_accepted < QUIET_HI);
		while (!quiet && $urandom_range(0, 99) < 13) begin
			item_if.valid <= 1'b0;
			@(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.kind <= it.kind;
		{item_if.third_z, item_if.third_y, item_if.third_x, item_if.second_z,
			item_if.second_y, item_if.second_x, item_if.first_z, item_if.first_y,
			item_if.first_x} <= it.c;
		do
			@(posedge clk);
		while (!item_if.ready);
		n_accepted++;
		h = predict_hit(it);
		if (it.kind == KIND_LOAD)
			last_plane_pt = it.c[2:0];
		else
			pending_hits.push_back(typed ? typed_hit : h);
		@(negedge clk);
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (n_accepted == PRESSURE_AT && hold_left == 0)
				hold_left = PRESSURE_LEN;
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= (hold_left == 0);
			end else if (n_accepted >= QUIET_LO && n_accepted < QUIET_HI) begin
				result_if.ready <= 1'b1;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= 13);
			end
		end
	end

	always @(posedge clk) begin
		hit_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_hits.size() == 0) begin
				$display("unexpected result transaction at %0t", $realtime);
				n_fail++;
			end else begin
				want = pending_hits.pop_front();
				if (result_if.hit_x !== want.x) report_mismatch("hit_x", result_if.hit_x, want.x);
				if (result_if.hit_y !== want.y) report_mismatch("hit_y", result_if.hit_y, want.y);
				if (result_if.hit_z !== want.z) report_mismatch("hit_z", result_if.hit_z, want.z);
				if (result_if.is_parallel !== want.par)
					report_mismatch("is_parallel", result_if.is_parallel, want.par);
				if (result_if.start_on_plane !== want.onp)
					report_mismatch("start_on_plane", result_if.start_on_plane, want.onp);
				if (result_if.clipped !== want.clip)
					report_mismatch("clipped", result_if.clipped, want.clip);
			end
		end
	end

	initial begin
		n_fail = 0;
		n_accepted = 0;
		nrm_a = 0; nrm_b = 0; nrm_c = 0; offset_d = 0;
		last_plane_pt = '0;
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.kind = KIND_LOAD;
		{item_if.third_z, item_if.third_y, item_if.third_x, item_if.second_z,
			item_if.second_y, item_if.second_x, item_if.first_z, item_if.first_y,
			item_if.first_x} = '0;

		// line before any plane: all-zero plane, both flags, start point back
		add_row(KIND_LINE, 11, -22, 33, 100, 200, 300, 0, 0, 0, 1, 11, -22, 33, 1, 1, 0);
		add_row(KIND_LOAD, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, 5, 6, -10, 5, 6, 10, -1, -1, -1, 1, 5, 6, 0, 0, 0, 0);
		// parallel to the plane
		add_row(KIND_LINE, 1, 2, 3, 4, 5, 3, 0, 0, 0, 1, 1, 2, 3, 1, 0, 0);
		// start on the plane
		add_row(KIND_LINE, 7, 8, 0, 1, 1, 5, 0, 0, 0, 1, 7, 8, 0, 0, 1, 0);
		// degenerate line on the plane: both flags
		add_row(KIND_LINE, 9, 9, 0, 9, 9, 0, 0, 0, 0, 1, 9, 9, 0, 1, 1, 0);
		add_row(KIND_LINE, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, 30000, 0, 1, -30000, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, -32768, 32767, 1, 32767, -32768, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, 3, 4, 7, 5, 9, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// collinear points: zero normal
		add_row(KIND_LOAD, 1, 1, 1, 2, 2, 2, 3, 3, 3, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, -5, 7, 9, 100, -100, 50, 0, 0, 0, 1, -5, 7, 9, 1, 1, 0);
		// extreme plane points
		add_row(KIND_LOAD, -32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767,
			32767, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, 32767, 32767, -32768, -32768, -32768, 32767, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, 0, 0, 0, 1, -1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LOAD, 32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767,
			0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, 32767, 32767, 32767, -32768, -32768, -32768, -1, -1, -1,
			0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_LINE, 1, 2, 3, 2, 3, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].hit);
		for (int i = 0; i < N_RANDOM; i++)
			send_item(rand_item(), 1'b0, '0);
		item_if.valid <= 1'b0;

		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_hits.size() != 0) begin
			$display("%0d results never arrived", pending_hits.size());
			n_fail++;
		end
		if (n_fail == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/spi_pkg.sv
hw/rtl/spi_in_if.sv
hw/rtl/spi_out_if.sv
hw/rtl/spi_shared_unit.sv
hw/rtl/segment_plane_intersect_core.sv
tb/segment_plane_intersect_core_tb.sv
